/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active-low reset disable
`define DCSH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("dcsh assertion failed");

// overlapping implication form
`define DCSH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `DCSH_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

/* sv/dcsh_pkg.sv */
// package: constants, codes and types of the sample history trigger block
package dcsh_pkg;

  localparam int RingDepth  = 64;
  localparam int SampleBits = 10;
  localparam int PtrW       = $clog2(RingDepth);

  localparam logic [PtrW-1:0] PtrLast = PtrW'(RingDepth - 1);

  localparam logic [2:0] FuncTick      = 3'd0;
  localparam logic [2:0] FuncSetLight  = 3'd1;
  localparam logic [2:0] FuncSetSound  = 3'd2;
  localparam logic [2:0] FuncReadLight = 3'd3;
  localparam logic [2:0] FuncReadSound = 3'd4;
  localparam logic [2:0] FuncFetch     = 3'd5;
  localparam logic [2:0] FuncIdent     = 3'd6;

  localparam logic [2:0] KindTick   = 3'd0;
  localparam logic [2:0] KindSample = 3'd1;
  localparam logic [2:0] KindEnd    = 3'd2;
  localparam logic [2:0] KindReport = 3'd3;
  localparam logic [2:0] KindIdent  = 3'd4;
  localparam logic [2:0] KindEcho   = 3'd5;

  localparam logic [1:0] CfgChecksum = 2'd0;
  localparam logic [1:0] CfgVersion  = 2'd1;
  localparam logic [1:0] CfgIdent    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StTickLight,
    StTickSound,
    StExec,
    StRdAddr,
    StRdData
  } seq_state_e;

  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    logic [PtrW-1:0] rd_addr;
  } ring_ctl_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [7:0]  version;
    logic [7:0]  ident;
  } ident_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        last;
    logic        irq;
  } result_t;

  function automatic logic [SampleBits-1:0] fit_sample(logic [9:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[SampleBits-1:0];
  endfunction

endpackage

/* sv/dcsh_cmp.sv */
// shared trigger compare unit: nonzero trigger and sample at or above it
module dcsh_cmp (
  input  logic [dcsh_pkg::SampleBits-1:0] sample_i,
  input  logic [15:0]                     trig_i,
  output logic                            hit_o
);

  logic [15:0] sample_w;

  assign sample_w = 16'(sample_i);
  assign hit_o    = (trig_i != 16'd0) && (sample_w >= trig_i);

endmodule

/* sv/dcsh_ring.sv */
// history ring: sample memory, write position and fill tracking
module dcsh_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcsh_pkg::ring_ctl_t             ctl_i,
  input  logic [dcsh_pkg::SampleBits-1:0] wr_data_i,
  output logic [dcsh_pkg::PtrW-1:0]       wpos_o,
  output logic [dcsh_pkg::SampleBits-1:0] rd_data_o
);

  logic [dcsh_pkg::SampleBits-1:0] mem_q [dcsh_pkg::RingDepth];
  logic [dcsh_pkg::SampleBits-1:0] rd_data_q;
  logic                            rd_valid_q, rd_valid_d;
  logic [dcsh_pkg::PtrW-1:0]       wpos_q, wpos_d;
  logic                            wrapped_q, wrapped_d;

  always_comb begin
    wpos_d    = wpos_q;
    wrapped_d = wrapped_q;
    if (ctl_i.wr_en) begin
      if (wpos_q == dcsh_pkg::PtrLast) begin
        wpos_d    = '0;
        wrapped_d = 1'b1;
      end else begin
        wpos_d = wpos_q + dcsh_pkg::PtrW'(1);
      end
    end
  end

  // entries never written read as zero
  assign rd_valid_d = wrapped_q || (ctl_i.rd_addr < wpos_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wpos_q] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      wrapped_q  <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      wpos_q    <= wpos_d;
      wrapped_q <= wrapped_d;
      if (ctl_i.rd_en) begin
        rd_valid_q <= rd_valid_d;
      end
    end
  end

  assign wpos_o    = wpos_q;
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* sv/dcsh_seq.sv */
// command sequencer: triggers, latches, interrupt and readback walk
module dcsh_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [2:0]                      func_i,
  input  logic [9:0]                      light_sample_i,
  input  logic [9:0]                      sound_sample_i,
  input  logic [15:0]                     trigger_value_i,
  input  logic [5:0]                      read_count_i,
  input  dcsh_pkg::ident_t                ident_i,
  input  logic [dcsh_pkg::PtrW-1:0]       light_wpos_i,
  input  logic [dcsh_pkg::PtrW-1:0]       sound_wpos_i,
  input  logic [dcsh_pkg::SampleBits-1:0] light_rd_i,
  input  logic [dcsh_pkg::SampleBits-1:0] sound_rd_i,
  output dcsh_pkg::ring_ctl_t             light_ctl_o,
  output dcsh_pkg::ring_ctl_t             sound_ctl_o,
  output logic [dcsh_pkg::SampleBits-1:0] light_wdata_o,
  output logic [dcsh_pkg::SampleBits-1:0] sound_wdata_o,
  output logic                            busy_o,
  output logic                            res_valid_o,
  output dcsh_pkg::result_t               res_o
);

  dcsh_pkg::seq_state_e            state_q, state_d;
  logic [2:0]                      func_q, func_d;
  logic [dcsh_pkg::SampleBits-1:0] ls_q, ls_d, ss_q, ss_d;
  logic [15:0]                     tv_q, tv_d;
  logic [5:0]                      cnt_q, cnt_d;
  logic [dcsh_pkg::PtrW-1:0]       ptr_q, ptr_d, ptr_dec;
  logic [15:0]                     light_trig_q, light_trig_d;
  logic [15:0]                     sound_trig_q, sound_trig_d;
  logic [dcsh_pkg::SampleBits-1:0] light_lat_q, light_lat_d;
  logic [dcsh_pkg::SampleBits-1:0] sound_lat_q, sound_lat_d;
  logic                            irq_q, irq_d;
  logic [dcsh_pkg::SampleBits-1:0] cmp_sample;
  logic [15:0]                     cmp_trig;
  logic                            cmp_hit;
  logic                            rd_sound;
  logic [dcsh_pkg::SampleBits-1:0] rd_word;

  // one compare unit serves both channels on successive cycles
  dcsh_cmp u_cmp (
    .sample_i (cmp_sample),
    .trig_i   (cmp_trig),
    .hit_o    (cmp_hit)
  );

  assign cmp_sample = (state_q == dcsh_pkg::StTickSound) ? ss_q : ls_q;
  assign cmp_trig   = (state_q == dcsh_pkg::StTickSound) ? sound_trig_q : light_trig_q;

  assign rd_sound = (func_q == dcsh_pkg::FuncReadSound);
  assign rd_word  = rd_sound ? sound_rd_i : light_rd_i;
  assign ptr_dec  = (ptr_q == '0) ? dcsh_pkg::PtrLast : ptr_q - dcsh_pkg::PtrW'(1);

  assign light_wdata_o = ls_q;
  assign sound_wdata_o = ss_q;
  assign busy_o        = (state_q != dcsh_pkg::StIdle);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    ls_d         = ls_q;
    ss_d         = ss_q;
    tv_d         = tv_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    light_trig_d = light_trig_q;
    sound_trig_d = sound_trig_q;
    light_lat_d  = light_lat_q;
    sound_lat_d  = sound_lat_q;
    irq_d        = irq_q;
    light_ctl_o  = '0;
    sound_ctl_o  = '0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (state_q)
      dcsh_pkg::StIdle: begin
        if (start_i) begin
          func_d = func_i;
          ls_d   = dcsh_pkg::fit_sample(light_sample_i);
          ss_d   = dcsh_pkg::fit_sample(sound_sample_i);
          tv_d   = trigger_value_i;
          cnt_d  = read_count_i;
          case (func_i)
            dcsh_pkg::FuncTick: begin
              state_d = dcsh_pkg::StTickLight;
            end
            dcsh_pkg::FuncReadLight: begin
              ptr_d   = light_wpos_i;
              state_d = dcsh_pkg::StRdAddr;
            end
            dcsh_pkg::FuncReadSound: begin
              ptr_d   = sound_wpos_i;
              state_d = dcsh_pkg::StRdAddr;
            end
            default: begin
              state_d = dcsh_pkg::StExec;
            end
          endcase
        end
      end
      dcsh_pkg::StTickLight: begin
        light_ctl_o.wr_en = 1'b1;
        if (cmp_hit) begin
          light_lat_d = ls_q;
          irq_d       = 1'b1;
        end
        state_d = dcsh_pkg::StTickSound;
      end
      dcsh_pkg::StTickSound: begin
        sound_ctl_o.wr_en = 1'b1;
        if (cmp_hit) begin
          sound_lat_d = ss_q;
          irq_d       = 1'b1;
        end
        res_valid_o  = 1'b1;
        res_o.kind   = dcsh_pkg::KindTick;
        res_o.word_a = 16'(ls_q);
        res_o.word_b = 16'(ss_q);
        res_o.last   = 1'b1;
        state_d      = dcsh_pkg::StIdle;
      end
      dcsh_pkg::StExec: begin
        state_d = dcsh_pkg::StIdle;
        case (func_q)
          dcsh_pkg::FuncSetLight: begin
            light_trig_d = tv_q;
            res_valid_o  = 1'b1;
            res_o.kind   = dcsh_pkg::KindEcho;
            res_o.word_a = tv_q;
            res_o.last   = 1'b1;
          end
          dcsh_pkg::FuncSetSound: begin
            sound_trig_d = tv_q;
            res_valid_o  = 1'b1;
            res_o.kind   = dcsh_pkg::KindEcho;
            res_o.word_a = tv_q;
            res_o.last   = 1'b1;
          end
          dcsh_pkg::FuncFetch: begin
            light_lat_d  = '0;
            sound_lat_d  = '0;
            irq_d        = 1'b0;
            res_valid_o  = 1'b1;
            res_o.kind   = dcsh_pkg::KindReport;
            res_o.word_a = 16'(light_lat_q);
            res_o.word_b = 16'(sound_lat_q);
            res_o.last   = 1'b1;
          end
          dcsh_pkg::FuncIdent: begin
            res_valid_o  = 1'b1;
            res_o.kind   = dcsh_pkg::KindIdent;
            res_o.word_a = ident_i.checksum;
            res_o.word_b = {ident_i.version, ident_i.ident};
            res_o.last   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      dcsh_pkg::StRdAddr: begin
        if (cnt_q == 6'd0) begin
          res_valid_o = 1'b1;
          res_o.kind  = dcsh_pkg::KindEnd;
          res_o.last  = 1'b1;
          state_d     = dcsh_pkg::StIdle;
        end else begin
          ptr_d = ptr_dec;
          cnt_d = cnt_q - 6'd1;
          if (rd_sound) begin
            sound_ctl_o.rd_en   = 1'b1;
            sound_ctl_o.rd_addr = ptr_dec;
          end else begin
            light_ctl_o.rd_en   = 1'b1;
            light_ctl_o.rd_addr = ptr_dec;
          end
          state_d = dcsh_pkg::StRdData;
        end
      end
      dcsh_pkg::StRdData: begin
        res_valid_o  = 1'b1;
        res_o.kind   = dcsh_pkg::KindSample;
        res_o.word_a = 16'(rd_word);
        state_d      = dcsh_pkg::StRdAddr;
      end
      default: begin
        state_d = dcsh_pkg::StIdle;
      end
    endcase

    res_o.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dcsh_pkg::StIdle;
      light_trig_q <= '0;
      sound_trig_q <= '0;
      light_lat_q  <= '0;
      sound_lat_q  <= '0;
      irq_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      light_trig_q <= light_trig_d;
      sound_trig_q <= sound_trig_d;
      light_lat_q  <= light_lat_d;
      sound_lat_q  <= sound_lat_d;
      irq_q        <= irq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    ls_q   <= ls_d;
    ss_q   <= ss_d;
    tv_q   <= tv_d;
    cnt_q  <= cnt_d;
    ptr_q  <= ptr_d;
  end

endmodule

/* sv/dual_channel_sample_history_trigger.sv */
// tick: busy through the light and sound steps; set, fetch and identify run in the exec state
// n-sample readback: address and data step per sample, one memory read each, then end marker
// results are registered from the sequencer step that makes them, strobed by valid_o
// a new command is taken once busy is low; results cannot be held off
// reset: checksum ffff, control cleared; unwritten entries read zero via wpos and wrap flag
// top level: configuration registers, history rings, sequencer and result register
module dual_channel_sample_history_trigger (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [9:0]  light_sample_i,
  input  logic [9:0]  sound_sample_i,
  input  logic [15:0] trigger_value_i,
  input  logic [5:0]  read_count_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        valid_o,
  output logic [2:0]  kind_o,
  output logic [15:0] word_a_o,
  output logic [15:0] word_b_o,
  output logic        last_flag_o,
  output logic        irq_level_o
);

  dcsh_pkg::ident_t                ident_q, ident_d;
  dcsh_pkg::ring_ctl_t             light_ctl, sound_ctl;
  logic [dcsh_pkg::SampleBits-1:0] light_wdata, sound_wdata;
  logic [dcsh_pkg::SampleBits-1:0] light_rd, sound_rd;
  logic [dcsh_pkg::PtrW-1:0]       light_wpos, sound_wpos;
  logic                            res_valid;
  dcsh_pkg::result_t               res, res_q;
  logic                            valid_q;

  always_comb begin
    ident_d = ident_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dcsh_pkg::CfgChecksum: ident_d.checksum = cfg_data_i;
        dcsh_pkg::CfgVersion:  ident_d.version  = cfg_data_i[7:0];
        dcsh_pkg::CfgIdent:    ident_d.ident    = cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q.checksum <= 16'hFFFF;
      ident_q.version  <= '0;
      ident_q.ident    <= '0;
      valid_q          <= 1'b0;
    end else begin
      ident_q <= ident_d;
      valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  dcsh_ring u_light_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (light_ctl),
    .wr_data_i (light_wdata),
    .wpos_o    (light_wpos),
    .rd_data_o (light_rd)
  );

  dcsh_ring u_sound_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sound_ctl),
    .wr_data_i (sound_wdata),
    .wpos_o    (sound_wpos),
    .rd_data_o (sound_rd)
  );

  dcsh_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .func_i          (func_i),
    .light_sample_i  (light_sample_i),
    .sound_sample_i  (sound_sample_i),
    .trigger_value_i (trigger_value_i),
    .read_count_i    (read_count_i),
    .ident_i         (ident_q),
    .light_wpos_i    (light_wpos),
    .sound_wpos_i    (sound_wpos),
    .light_rd_i      (light_rd),
    .sound_rd_i      (sound_rd),
    .light_ctl_o     (light_ctl),
    .sound_ctl_o     (sound_ctl),
    .light_wdata_o   (light_wdata),
    .sound_wdata_o   (sound_wdata),
    .busy_o          (busy),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  assign valid_o     = valid_q;
  assign kind_o      = res_q.kind;
  assign word_a_o    = res_q.word_a;
  assign word_b_o    = res_q.word_b;
  assign last_flag_o = res_q.last;
  assign irq_level_o = res_q.irq;

endmodule

/* sv/dcsh_checker.sv */
// port-level checker for the sample history trigger block and its bind
`include "assert_macros.svh"

module dcsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        valid_o,
  input logic [2:0]  kind_o,
  input logic [15:0] word_a_o,
  input logic [15:0] word_b_o,
  input logic        last_flag_o,
  input logic        irq_level_o
);

  logic report_w;
  logic end_w;
  logic end_ok_w;

  assign report_w = valid_o && (kind_o == dcsh_pkg::KindReport);
  assign end_w    = valid_o && (kind_o == dcsh_pkg::KindEnd);
  assign end_ok_w = last_flag_o && (word_a_o == 16'd0) && (word_b_o == 16'd0);

  `DCSH_ASSERT_IMPL(a_word_after_busy, clk_i, rst_ni, valid_o, $past(busy))
  `DCSH_ASSERT_IMPL(a_last_frees, clk_i, rst_ni, valid_o && last_flag_o, !busy)
  `DCSH_ASSERT_IMPL(a_more_follows, clk_i, rst_ni, valid_o && !last_flag_o, busy)
  `DCSH_ASSERT_IMPL(a_fetch_clears, clk_i, rst_ni, report_w, !irq_level_o)
  `DCSH_ASSERT_IMPL(a_end_marker, clk_i, rst_ni, end_w, end_ok_w)

endmodule

bind dual_channel_sample_history_trigger dcsh_checker u_dcsh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .valid_o     (valid_o),
  .kind_o      (kind_o),
  .word_a_o    (word_a_o),
  .word_b_o    (word_b_o),
  .last_flag_o (last_flag_o),
  .irq_level_o (irq_level_o)
);

/* verif/testbench.sv */
// testbench for the dual channel sample history trigger block: queued commands, predicted words
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] FuncUnused = 3'd7;
  localparam int CycleLimit = 300000;
  localparam int IdleMargin = 200;
  localparam int ReportCap  = 40;

  typedef struct {
    logic [2:0]  func;
    logic [9:0]  light;
    logic [9:0]  sound;
    logic [15:0] trig;
    logic [5:0]  count;
    int unsigned gap;
    bit          drain;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func_i = '0;
  logic [9:0]  light_sample_i = '0;
  logic [9:0]  sound_sample_i = '0;
  logic [15:0] trigger_value_i = '0;
  logic [5:0]  read_count_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        valid_o;
  logic [2:0]  kind_o;
  logic [15:0] word_a_o;
  logic [15:0] word_b_o;
  logic        last_flag_o;
  logic        irq_level_o;

  command_t          cmd_backlog[$];
  dcsh_pkg::result_t awaited_words[$];
  command_t          cur_cmd;
  dcsh_pkg::result_t head_word;
  int unsigned       gap_count = 0;
  bit                can_load;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;

  // predictor state
  logic [dcsh_pkg::SampleBits-1:0] light_hist[dcsh_pkg::RingDepth];
  logic [dcsh_pkg::SampleBits-1:0] sound_hist[dcsh_pkg::RingDepth];
  logic [dcsh_pkg::PtrW-1:0]       light_wp = '0;
  logic [dcsh_pkg::PtrW-1:0]       sound_wp = '0;
  logic [15:0]                     light_trig = '0;
  logic [15:0]                     sound_trig = '0;
  logic [dcsh_pkg::SampleBits-1:0] light_held = '0;
  logic [dcsh_pkg::SampleBits-1:0] sound_held = '0;
  logic                            irq_held = 1'b0;
  logic [15:0]                     cfg_checksum = 16'hffff;
  logic [7:0]                      cfg_version = '0;
  logic [7:0]                      cfg_ident = '0;

  dual_channel_sample_history_trigger i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .light_sample_i  (light_sample_i),
    .sound_sample_i  (sound_sample_i),
    .trigger_value_i (trigger_value_i),
    .read_count_i    (read_count_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .valid_o         (valid_o),
    .kind_o          (kind_o),
    .word_a_o        (word_a_o),
    .word_b_o        (word_b_o),
    .last_flag_o     (last_flag_o),
    .irq_level_o     (irq_level_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    if (mismatch_count < ReportCap) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic dcsh_pkg::result_t make_word(logic [2:0] kind, logic [15:0] a,
                                                  logic [15:0] b, logic last);
    dcsh_pkg::result_t w;
    w.kind   = kind;
    w.word_a = a;
    w.word_b = b;
    w.last   = last;
    w.irq    = irq_held;
    return w;
  endfunction

  task automatic compute_words(command_t c);
    logic [dcsh_pkg::PtrW-1:0]       rp;
    logic [dcsh_pkg::SampleBits-1:0] la;
    logic [dcsh_pkg::SampleBits-1:0] sa;
    case (c.func)
      dcsh_pkg::FuncTick: begin
        light_hist[light_wp] = c.light;
        if (light_trig != 0 && 16'(c.light) >= light_trig) begin
          light_held = c.light;
          irq_held   = 1'b1;
        end
        light_wp = light_wp + dcsh_pkg::PtrW'(1);
        sound_hist[sound_wp] = c.sound;
        if (sound_trig != 0 && 16'(c.sound) >= sound_trig) begin
          sound_held = c.sound;
          irq_held   = 1'b1;
        end
        sound_wp = sound_wp + dcsh_pkg::PtrW'(1);
        awaited_words.push_back(make_word(dcsh_pkg::KindTick, 16'(c.light), 16'(c.sound),
                                          1'b1));
      end
      dcsh_pkg::FuncSetLight: begin
        light_trig = c.trig;
        awaited_words.push_back(make_word(dcsh_pkg::KindEcho, c.trig, 16'h0, 1'b1));
      end
      dcsh_pkg::FuncSetSound: begin
        sound_trig = c.trig;
        awaited_words.push_back(make_word(dcsh_pkg::KindEcho, c.trig, 16'h0, 1'b1));
      end
      dcsh_pkg::FuncReadLight, dcsh_pkg::FuncReadSound: begin
        rp = (c.func == dcsh_pkg::FuncReadLight) ? light_wp : sound_wp;
        for (int i = 0; i < c.count; i++) begin
          rp = rp - dcsh_pkg::PtrW'(1);
          awaited_words.push_back(make_word(dcsh_pkg::KindSample,
            16'((c.func == dcsh_pkg::FuncReadLight) ? light_hist[rp] : sound_hist[rp]),
            16'h0, 1'b0));
        end
        awaited_words.push_back(make_word(dcsh_pkg::KindEnd, 16'h0, 16'h0, 1'b1));
      end
      dcsh_pkg::FuncFetch: begin
        la = light_held;
        sa = sound_held;
        light_held = '0;
        sound_held = '0;
        irq_held   = 1'b0;
        awaited_words.push_back(make_word(dcsh_pkg::KindReport, 16'(la), 16'(sa), 1'b1));
      end
      dcsh_pkg::FuncIdent: begin
        awaited_words.push_back(make_word(dcsh_pkg::KindIdent, cfg_checksum,
                                          {cfg_version, cfg_ident}, 1'b1));
      end
      default: ;
    endcase
  endtask

  // driver: one command held on the bus until start meets busy low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      can_load = !start;
      if (start && !busy) begin
        compute_words(cur_cmd);
        can_load = 1'b1;
      end
      if (can_load) begin
        if (cmd_backlog.size() != 0 && gap_count >= cmd_backlog[0].gap &&
            (!cmd_backlog[0].drain || (awaited_words.size() == 0 && !busy))) begin
          cur_cmd = cmd_backlog.pop_front();
          start           <= 1'b1;
          func_i          <= cur_cmd.func;
          light_sample_i  <= cur_cmd.light;
          sound_sample_i  <= cur_cmd.sound;
          trigger_value_i <= cur_cmd.trig;
          read_count_i    <= cur_cmd.count;
          gap_count = 0;
        end else begin
          start <= 1'b0;
          gap_count++;
        end
      end
    end
  end

  // monitor: every strobed word is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d a %h b %h", kind_o, word_a_o,
                                word_b_o));
      end else begin
        head_word = awaited_words.pop_front();
        if (kind_o !== head_word.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", kind_o, head_word.kind));
        if (word_a_o !== head_word.word_a)
          flag_mismatch($sformatf("word_a %h, want %h", word_a_o, head_word.word_a));
        if (word_b_o !== head_word.word_b)
          flag_mismatch($sformatf("word_b %h, want %h", word_b_o, head_word.word_b));
        if (last_flag_o !== head_word.last)
          flag_mismatch($sformatf("last_flag %b, want %b", last_flag_o, head_word.last));
        if (irq_level_o !== head_word.irq)
          flag_mismatch($sformatf("irq_level %b, want %b", irq_level_o, head_word.irq));
      end
    end
  end

  function automatic command_t build_cmd(logic [2:0] func, logic [9:0] light, logic [9:0] sound,
                                         logic [15:0] trig, logic [5:0] count);
    command_t c;
    c.func  = func;
    c.light = light;
    c.sound = sound;
    c.trig  = trig;
    c.count = count;
    c.gap   = $urandom_range(0, 10);
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic command_t random_cmd(bit burst);
    command_t    c;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    c = build_cmd(dcsh_pkg::FuncTick, 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                  6'($urandom_range(0, 63)));
    if (pick < 45)      c.func = dcsh_pkg::FuncTick;
    else if (pick < 50) c.func = dcsh_pkg::FuncSetLight;
    else if (pick < 55) c.func = dcsh_pkg::FuncSetSound;
    else if (pick < 65) c.func = dcsh_pkg::FuncReadLight;
    else if (pick < 75) c.func = dcsh_pkg::FuncReadSound;
    else if (pick < 87) c.func = dcsh_pkg::FuncFetch;
    else if (pick < 96) c.func = dcsh_pkg::FuncIdent;
    else                c.func = FuncUnused;
    sel = $urandom_range(0, 99);
    if (sel < 60)      c.trig = 16'($urandom_range(1, 1023));
    else if (sel < 75) c.trig = 16'h0;
    sel = $urandom_range(0, 99);
    if (sel < 80)      c.count = 6'($urandom_range(0, 8));
    else if (sel < 95) c.count = 6'($urandom_range(9, 40));
    if (burst) c.gap = 0;
    c.drain = ($urandom_range(0, 39) == 0);
    return c;
  endfunction

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      dcsh_pkg::CfgChecksum: cfg_checksum = value;
      dcsh_pkg::CfgVersion:  cfg_version  = value[7:0];
      dcsh_pkg::CfgIdent:    cfg_ident    = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued command went out and every predicted word came back
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || awaited_words.size() != 0 || busy);
    repeat (IdleMargin) @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) cmd_backlog.push_back(random_cmd(((i / 20) % 3) == 0));
  endtask

  initial begin
    command_t c;
    for (int i = 0; i < dcsh_pkg::RingDepth; i++) begin
      light_hist[i] = '0;
      sound_hist[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed opening with reset register values
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncIdent, 10'h0, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncReadLight, 10'h3ff, 10'h3ff, 16'hffff, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncReadSound, 10'h0, 10'h0, 16'h0, 6'd5));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncFetch, 10'h0, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncSetLight, 10'h0, 10'h0, 16'h0200, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncSetSound, 10'h0, 10'h0, 16'hffff, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h3ff, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h1ff, 10'h3ff, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h200, 10'h155, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(FuncUnused, 10'h3ff, 10'h3ff, 16'hffff, 6'd63));
    c = build_cmd(dcsh_pkg::FuncFetch, 10'h0, 10'h0, 16'h0, 6'd0);
    c.drain = 1'b1;
    cmd_backlog.push_back(c);
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncSetSound, 10'h0, 10'h0, 16'h0001, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h0, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h155, 10'h2aa, 16'h5555, 6'd42));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncSetLight, 10'h0, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncTick, 10'h3ff, 10'h3ff, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncReadLight, 10'h0, 10'h0, 16'h0, 6'd63));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncReadSound, 10'h0, 10'h0, 16'h0, 6'd3));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncFetch, 10'h0, 10'h0, 16'h0, 6'd0));
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncIdent, 10'h0, 10'h0, 16'h0, 6'd0));
    settle();

    write_register(dcsh_pkg::CfgChecksum, 16'h0000);
    write_register(dcsh_pkg::CfgVersion, 16'h00ff);
    write_register(dcsh_pkg::CfgIdent, 16'h0000);
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncIdent, 10'h0, 10'h0, 16'h0, 6'd0));
    random_phase(80);
    settle();

    write_register(dcsh_pkg::CfgChecksum, 16'hffff);
    write_register(dcsh_pkg::CfgVersion, 16'h0000);
    write_register(dcsh_pkg::CfgIdent, 16'h00ff);
    cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncIdent, 10'h0, 10'h0, 16'h0, 6'd0));
    random_phase(80);
    settle();

    for (int p = 0; p < 2; p++) begin
      write_register(dcsh_pkg::CfgChecksum, 16'($urandom_range(0, 65535)));
      write_register(dcsh_pkg::CfgVersion, 16'($urandom_range(0, 255)));
      write_register(dcsh_pkg::CfgIdent, 16'($urandom_range(0, 255)));
      cmd_backlog.push_back(build_cmd(dcsh_pkg::FuncIdent, 10'h0, 10'h0, 16'h0, 6'd0));
      random_phase(85);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/dcsh_pkg.sv
sv/dcsh_cmp.sv
sv/dcsh_ring.sv
sv/dcsh_seq.sv
sv/dual_channel_sample_history_trigger.sv
sv/dcsh_checker.sv
verif/testbench.sv
